[rtl/lkt_pkg.sv]
// Shared types and constants for the LRU key tracker.
`default_nettype none
package lkt_pkg;

  localparam int KEY_W            = 64;
  localparam int CNT_W            = 5;
  localparam int DEF_MAX_ENTRIES  = 16;
  localparam int CAP_RESET        = 16;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_ADDR_W       = 3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic             sample;   // register the compare result for in_key
    logic             shift_all;// new key enters slot 0, everything moves down
    logic             grow;     // with shift_all: valid run grows by one
    logic             touch;    // cells at or above the hit move down
    logic             remove;   // cells at or below the hit move up
    logic             clear;
    logic             trim;     // drop slots at or beyond lim
    logic [CNT_W-1:0] lim;
  } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/lru_key_tracker.sv]
// Top level: command control, capacity register and the row of slot cells.
// A command has an accept step and an update step: at the accepting edge every slot
// compares its key with in_key and registers a hit; in the next cycle the row shifts by
// one place (insert, touch or remove) and the result is registered, so busy is high for
// one cycle after each accept, blocking a new command until the update ends. The result
// appears for one cycle with out_valid high, in the cycle after the update; the receiver
// cannot stall it. Slot 0 holds the most recent key. A write of capacity_limit below the
// current occupancy drops the least recent keys at once, with no eviction reported.
`default_nettype none
module lru_key_tracker #(
  parameter int MAX_ENTRIES = lkt_pkg::DEF_MAX_ENTRIES
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  lkt_pkg::cmd_t              in_cmd,
  input  wire  [lkt_pkg::KEY_W-1:0]        in_key,
  output logic                             out_valid,
  output logic                             out_found,
  output logic                             out_evicted,
  output logic [lkt_pkg::KEY_W-1:0]        out_evicted_key,
  output logic [lkt_pkg::CNT_W-1:0]        out_occupancy,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [lkt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [lkt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lkt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import lkt_pkg::*;

  localparam int LIM_MAX = (MAX_ENTRIES > 31) ? 31 : MAX_ENTRIES;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]  cap_r, cap_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  lim, new_lim;
  logic              out_valid_r, out_found_r, out_evicted_r;
  logic [KEY_W-1:0]  out_ev_key_r;
  logic [CNT_W-1:0]  out_occ_r;
  logic              accept, upd, cfg_wr, hit_any, ins_miss, evict;
  reg_idx_t          reg_sel;
  cell_ctl_t         ctl;

  logic [KEY_W-1:0]       key_w   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_w;
  logic [MAX_ENTRIES:0]   suf_w;
  logic [MAX_ENTRIES:0]   pre_w;
  logic [KEY_W-1:0]       ev_w    [MAX_ENTRIES+1];

  function automatic logic [CNT_W-1:0] eff_lim(input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] r;
    r = cap;
    if (cap == '0) begin
      r = CNT_W'(1);
    end else if (32'(cap) > LIM_MAX) begin
      r = CNT_W'(LIM_MAX);
    end
    return r;
  endfunction

  assign busy    = (state_r == ST_UPD);
  assign accept  = start && !busy;
  assign upd     = (state_r == ST_UPD);
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_sel == REG_CAPACITY);
  assign prdata  = (reg_sel == REG_CAPACITY) ? CFG_DATA_W'(cap_r) : '0;

  assign lim      = eff_lim(cap_r);
  assign new_lim  = eff_lim(pwdata[CNT_W-1:0]);
  assign hit_any  = pre_w[MAX_ENTRIES];
  assign ins_miss = (cmd_r == CMD_INSERT) && !hit_any;
  assign evict    = ins_miss && (count_r >= lim);

  always_comb begin
    ctl           = '0;
    ctl.sample    = accept;
    ctl.shift_all = upd && ins_miss;
    ctl.grow      = !evict;
    ctl.touch     = upd && hit_any && ((cmd_r == CMD_INSERT) || (cmd_r == CMD_TOUCH));
    ctl.remove    = upd && hit_any && (cmd_r == CMD_REMOVE);
    ctl.clear     = upd && (cmd_r == CMD_CLEAR);
    ctl.trim      = cfg_wr;
    ctl.lim       = new_lim;
  end

  always_comb begin
    count_nxt = count_r;
    cap_nxt   = cap_r;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.remove) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (ctl.shift_all && !evict) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cfg_wr) begin
      cap_nxt = pwdata[CNT_W-1:0];
      if (count_r > new_lim) begin
        count_nxt = new_lim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CNT_W'(CAP_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= upd;
    end
  end

  // Hold the command beat; register the result during the update cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
    end
    if (upd) begin
      out_found_r   <= hit_any && (cmd_r != CMD_CLEAR);
      out_evicted_r <= evict;
      out_ev_key_r  <= evict ? ev_w[MAX_ENTRIES] : '0;
      out_occ_r     <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_ev_key_r;
  assign out_occupancy   = out_occ_r;

  assign suf_w[MAX_ENTRIES] = 1'b0;
  assign pre_w[0]           = 1'b0;
  assign ev_w[0]            = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0] lk, rk;
    logic             lv, rv;
    if (i == 0) begin : g_head
      assign lk = key_r;
      assign lv = 1'b1;
    end else begin : g_mid
      assign lk = key_w[i-1];
      assign lv = valid_w[i-1];
    end
    if (i == MAX_ENTRIES-1) begin : g_tail
      assign rk = '0;
      assign rv = 1'b0;
    end else begin : g_body
      assign rk = key_w[i+1];
      assign rv = valid_w[i+1];
    end
    lkt_cell #(.IDX(i)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .cmp_key     (in_key),
      .left_key    (lk),
      .left_valid  (lv),
      .right_key   (rk),
      .right_valid (rv),
      .suf_in      (suf_w[i+1]),
      .suf_out     (suf_w[i]),
      .pre_in      (pre_w[i]),
      .pre_out     (pre_w[i+1]),
      .ev_in       (ev_w[i]),
      .ev_out      (ev_w[i+1]),
      .key_q       (key_w[i]),
      .valid_q     (valid_w[i])
    );
  end

  logic [MAX_ENTRIES-1:0] exp_valid;
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      exp_valid[i] = (32'(i) < 32'(count_r));
    end
  end

  ap_count_le_lim: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lim) else $error("occupancy above limit");

  ap_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
    valid_w == exp_valid) else $error("valid slots do not match occupancy");

  ap_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> out_valid) else $error("missing result after update");

  ap_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (!out_found && out_occupancy == lim))
    else $error("eviction on a hit or below limit");

endmodule
`default_nettype wire

[rtl/lkt_cell.sv]
// One slot of the recency row: key, valid bit, hit flag and neighbor chains.
`default_nettype none
module lkt_cell #(
  parameter int IDX = 0
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  lkt_pkg::cell_ctl_t    ctl,
  input  wire  [lkt_pkg::KEY_W-1:0]   cmp_key,
  input  wire  [lkt_pkg::KEY_W-1:0]   left_key,
  input  wire                         left_valid,
  input  wire  [lkt_pkg::KEY_W-1:0]   right_key,
  input  wire                         right_valid,
  input  wire                         suf_in,
  output logic                        suf_out,
  input  wire                         pre_in,
  output logic                        pre_out,
  input  wire  [lkt_pkg::KEY_W-1:0]   ev_in,
  output logic [lkt_pkg::KEY_W-1:0]   ev_out,
  output logic [lkt_pkg::KEY_W-1:0]   key_q,
  output logic                        valid_q
);
  import lkt_pkg::*;

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             valid_r, valid_nxt;
  logic             hit_r, hit_nxt;
  logic             hit_ge, hit_le, is_last, trim_me;

  assign hit_ge  = hit_r | suf_in;
  assign hit_le  = hit_r | pre_in;
  assign suf_out = hit_ge;
  assign pre_out = hit_le;
  assign is_last = valid_r & ~right_valid;
  assign ev_out  = ev_in | (is_last ? key_r : '0);
  assign trim_me = (32'(IDX) >= 32'(ctl.lim));

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    hit_nxt   = hit_r;
    if (ctl.sample) begin
      hit_nxt = valid_r & (key_r == cmp_key);
    end
    if (ctl.shift_all) begin
      key_nxt = left_key;
      if (ctl.grow) begin
        valid_nxt = left_valid;
      end
    end else if (ctl.touch && hit_ge) begin
      key_nxt = left_key;
    end else if (ctl.remove && hit_le) begin
      key_nxt   = right_key;
      valid_nxt = right_valid;
    end else if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.trim && trim_me) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q   = key_r;
  assign valid_q = valid_r;

endmodule
`default_nettype wire

[tb/sv/lru_key_tracker_test.sv]
// Self-checking testbench for the LRU key tracker: directed and random command streams.
module lru_key_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lkt_pkg::*;

  typedef logic [KEY_W-1:0] key_t;
  typedef bit bool_gaps_t;

  typedef struct packed {
    logic             found;
    logic             evicted;
    key_t             evicted_key;
    logic [CNT_W-1:0] occupancy;
  } outcome_t;

  localparam int LIST_DEPTH  = DEF_MAX_ENTRIES;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_WAIT  = 8;
  localparam int PRINT_LIMIT = 50;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  cmd_t                  in_cmd = CMD_INSERT;
  key_t                  in_key = '0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;

  logic                  busy;
  logic                  out_valid;
  logic                  out_found;
  logic                  out_evicted;
  key_t                  out_evicted_key;
  logic [CNT_W-1:0]      out_occupancy;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lru_key_tracker #(.MAX_ENTRIES(LIST_DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_key(in_key),
    .out_valid(out_valid), .out_found(out_found), .out_evicted(out_evicted),
    .out_evicted_key(out_evicted_key), .out_occupancy(out_occupancy),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the recency list: slot 0 is the most recent key.
  key_t             recency_keys [LIST_DEPTH];
  int               held_n = 0;
  logic [CNT_W-1:0] capacity_reg = CNT_W'(CAP_RESET);

  outcome_t pending_outcomes [$];
  int       error_count = 0;
  int       cycle_count = 0;
  key_t     key_pool [$];

  function automatic int effective_capacity();
    if (capacity_reg == 0) return 1;
    if (int'(capacity_reg) > LIST_DEPTH) return LIST_DEPTH;
    return int'(capacity_reg);
  endfunction

  function automatic outcome_t apply_command(cmd_t c, key_t k);
    outcome_t o;
    int       pos;
    int       i;
    o = '0;
    pos = -1;
    for (i = 0; i < held_n; i++) begin
      if (pos < 0 && recency_keys[i] == k) pos = i;
    end
    if (c == CMD_CLEAR) begin
      held_n = 0;
    end else if (pos >= 0) begin
      o.found = 1'b1;
      if (c == CMD_REMOVE) begin
        for (i = pos; i + 1 < held_n; i++) recency_keys[i] = recency_keys[i + 1];
        held_n--;
      end else begin
        for (i = pos; i > 0; i--) recency_keys[i] = recency_keys[i - 1];
        recency_keys[0] = k;
      end
    end else if (c == CMD_INSERT) begin
      if (held_n >= effective_capacity() && held_n > 0) begin
        o.evicted     = 1'b1;
        o.evicted_key = recency_keys[held_n - 1];
        held_n--;
      end
      for (i = held_n; i > 0; i--) recency_keys[i] = recency_keys[i - 1];
      recency_keys[0] = k;
      held_n++;
    end
    o.occupancy = CNT_W'(held_n);
    return o;
  endfunction

  function automatic key_t random_key();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Drive one command beat, wait for the accepting edge, then idle for the given gap, if any, before returning.
  task automatic send_command(cmd_t c, key_t k, int gap);
    start  <= 1'b1;
    in_cmd <= c;
    in_key <= k;
    do @(posedge clk); while (busy);
    pending_outcomes = {pending_outcomes, apply_command(c, k)};
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every expected beat has come back.
  task automatic settle();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == CFG_ADDR_W'(4 * REG_CAPACITY)) begin
      capacity_reg = data[CNT_W-1:0];
      // Lowering the limit trims the least recent keys without an eviction beat.
      if (held_n > effective_capacity()) held_n = effective_capacity();
    end
  endtask

  task automatic set_capacity(int value);
    logic [CFG_DATA_W-1:0] data;
    data = {$urandom};
    data[CNT_W-1:0] = CNT_W'(value);
    write_register(CFG_ADDR_W'(4 * REG_CAPACITY), data);
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst_n && out_valid) begin
      got = '{out_found, out_evicted, out_evicted_key, out_occupancy};
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %p", got));
      end else begin
        want = pending_outcomes.pop_front();
        if (got.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.evicted !== want.evicted)
          report_mismatch($sformatf("evicted %b, want %b", got.evicted, want.evicted));
        if (got.evicted_key !== want.evicted_key)
          report_mismatch($sformatf("evicted_key %h, want %h",
                                    got.evicted_key, want.evicted_key));
        if (got.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, want %0d",
                                    got.occupancy, want.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_key_tracker_test: errors");
      $finish;
    end
  end

  // Empty-list cases, both key extremes, hits, and a fill that ends in one eviction.
  task automatic test_directed_commands();
    int i;
    send_command(CMD_CLEAR, '0, pick_gap());
    send_command(CMD_TOUCH, '0, pick_gap());
    send_command(CMD_REMOVE, '1, pick_gap());
    send_command(CMD_INSERT, '0, pick_gap());
    send_command(CMD_INSERT, '1, pick_gap());
    send_command(CMD_INSERT, '1, pick_gap());
    send_command(CMD_TOUCH, '0, pick_gap());
    send_command(CMD_REMOVE, '1, pick_gap());
    send_command(CMD_REMOVE, '0, pick_gap());
    for (i = 0; i < LIST_DEPTH; i++)
      send_command(CMD_INSERT, {32'h5A5A_0000 | i, ~(32'h1 << i)}, 0);
    send_command(CMD_INSERT, 64'h8000_0000_0000_0001, pick_gap());
    settle();
  endtask

  // Out-of-range limits clamp, and lowering the limit trims silently.
  task automatic test_capacity_limits();
    int i;
    set_capacity(3);
    send_command(CMD_INSERT, random_key(), pick_gap());
    send_command(CMD_TOUCH, recency_keys[2], pick_gap());
    settle();
    set_capacity(0);
    send_command(CMD_INSERT, random_key(), 0);
    send_command(CMD_INSERT, random_key(), pick_gap());
    settle();
    set_capacity(31);
    for (i = 0; i < 4; i++) send_command(CMD_INSERT, random_key(), pick_gap());
    settle();
    set_capacity(17);
    send_command(CMD_INSERT, random_key(), pick_gap());
    settle();
    set_capacity(1);
    send_command(CMD_INSERT, random_key(), pick_gap());
    settle();
  endtask

  // A write to an unused address must leave the limit as it is.
  task automatic test_unknown_register();
    int i;
    set_capacity(4);
    write_register(CFG_ADDR_W'(4 * REG_NONE), 32'h0000_0001);
    for (i = 0; i < 6; i++) send_command(CMD_INSERT, random_key(), pick_gap());
    settle();
  endtask

  // Commands on a small key pool so hits, misses and evictions all stay frequent.
  task automatic test_random_traffic();
    int caps [8] = '{16, 1, 0, 31, 2, 9, 17, 5};
    int phase;
    int n;
    int r;
    int pool_n;
    bool_gaps_t gaps_on;
    cmd_t c;
    key_t k;
    for (phase = 0; phase < 8; phase++) begin
      if (phase >= 5) set_capacity($urandom_range(0, 31));
      else set_capacity(caps[phase]);
      pool_n = effective_capacity() + $urandom_range(1, 6);
      key_pool.delete();
      for (n = 0; n < pool_n; n++) key_pool = {key_pool, random_key()};
      gaps_on = ($urandom_range(0, 2) != 0);
      for (n = 0; n < 94; n++) begin
        r = $urandom_range(0, 99);
        if (r < 48) c = CMD_INSERT;
        else if (r < 72) c = CMD_TOUCH;
        else if (r < 96) c = CMD_REMOVE;
        else c = CMD_CLEAR;
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_n - 1)];
        else k = random_key();
        send_command(c, k, gaps_on ? pick_gap() : 0);
      end
      settle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_commands();
    test_capacity_limits();
    test_unknown_register();
    test_random_traffic();
    settle();
    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("lru_key_tracker_test: clean");
    end else begin
      $display("lru_key_tracker_test: errors");
    end
    $finish;
  end

endmodule
